>>> src/bffa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap first-fit allocator package
// Field widths, register map, operation and status codes, and the hit
// record that the word scanner hands back to the sequencer.
// ----------------------------------------------------------------------------
package bffa_pkg;

  localparam int WORD_W  = 32;
  localparam int BIT_W   = 5;
  localparam int REQ_W   = 15;
  localparam int FIRST_W = 10;
  localparam int START_W = 10;
  localparam int NEED_W  = 16;
  localparam int CFG_W   = 11;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CFG_W-1:0] BIU_RESET = 11'd1024;

  localparam logic REG_BLOCKS_IN_USE = 1'b0;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] pos;
  } scan_hit_t;

endpackage

>>> src/bffa_div.sv
// ----------------------------------------------------------------------------
// Block count divider
// Divides by a fixed divisor through a reciprocal multiplication; the
// quotient is ready in the cycle after start.
// ----------------------------------------------------------------------------
module bffa_div #(
  parameter int DIVISOR = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bffa_pkg::NEED_W-1:0] dividend,
  output logic                        done,
  output logic [bffa_pkg::NEED_W-1:0] quotient
);
  import bffa_pkg::*;

  // With NEED_W plus ceil(log2(DIVISOR)) fraction bits, the rounded-up
  // reciprocal gives the exact quotient for every NEED_W-bit dividend, and
  // it fits in NEED_W + 1 bits.
  localparam int DIV_SH = NEED_W + $clog2(DIVISOR);
  localparam int PROD_W = 2 * NEED_W + 1;
  localparam longint RECIP_L = ((longint'(1) << DIV_SH) + longint'(DIVISOR) - longint'(1))
                               / longint'(DIVISOR);
  localparam logic [NEED_W:0] RECIP = (NEED_W + 1)'(RECIP_L);

  logic [NEED_W-1:0] held;
  logic [PROD_W-1:0] product;

  assign product  = PROD_W'(held) * PROD_W'(RECIP);
  assign quotient = NEED_W'(product >> DIV_SH);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      held <= dividend;
    end
  end

endmodule

>>> src/bffa_word_scan.sv
// ----------------------------------------------------------------------------
// Free-run word scanner
// Finds the lowest bit of one bitmap word at which the run of free blocks,
// including the run carried in from lower words, reaches the requested length.
// ----------------------------------------------------------------------------
module bffa_word_scan #(
  parameter int LEN_W = 18
) (
  input  logic [bffa_pkg::WORD_W-1:0] word,
  input  logic [LEN_W-1:0]            carry,
  input  logic [LEN_W-1:0]            need,
  output bffa_pkg::scan_hit_t         result,
  output logic [LEN_W-1:0]            run_out
);
  import bffa_pkg::*;

  // zpos holds one plus the index of the highest busy bit at or below each
  // position, or zero when every bit up to there is free.
  logic [BIT_W:0]     zpos [BIT_W+1][WORD_W];
  logic [LEN_W-1:0]   run  [WORD_W];
  logic [WORD_W-1:0]  hit;

  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      zpos[0][j] = word[j] ? '0 : (BIT_W + 1)'(j + 1);
    end
    for (int l = 0; l < BIT_W; l++) begin
      for (int j = 0; j < WORD_W; j++) begin
        if (j >= (1 << l) && zpos[l][j] == '0) begin
          zpos[l+1][j] = zpos[l][j - (1 << l)];
        end else begin
          zpos[l+1][j] = zpos[l][j];
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      if (zpos[BIT_W][j] == '0) begin
        run[j] = carry + LEN_W'(j + 1);
      end else begin
        run[j] = LEN_W'(j + 1) - LEN_W'(zpos[BIT_W][j]);
      end
      hit[j] = (run[j] >= need);
    end
  end

  always_comb begin
    result.hit = |hit;
    result.pos = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (hit[j]) begin
        result.pos = BIT_W'(j);
      end
    end
  end

  assign run_out = run[WORD_W-1];

endmodule

>>> src/bitmap_first_fit_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap first-fit block allocator
// Free bitmap in a word-wide memory, one bit per block, with first-fit
// allocation and range free through a read-modify-write sequencer.
// ----------------------------------------------------------------------------
// One item is handled at a time. After reset a clearing pass writes the
// bitmap to all free, one word per cycle; input transfers wait for it to
// finish. After an input transfer the byte size is rounded up to blocks with
// a reciprocal multiplication, the request is checked against the pool, the
// scan reads one word per cycle from word 0, the run's bounds are set up, the
// mark loop does one read-modify-write per cycle over the run's words, the
// output register is loaded, and the idle step takes the next transfer. A
// free skips the scan, and a zero-size request, an allocate larger than the
// pool or a free that starts past the pool end go from the check straight to
// the output register.
// A result held back by out_stall keeps the block in its last step for as
// long as the stall lasts; a finished result waits in the output register
// while the next input transfer is taken.
module bitmap_first_fit_allocator #(
  parameter int MAX_BLOCKS  = 1024,
  parameter int BLOCK_BYTES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bffa_pkg::PADDR_W-1:0]  paddr,
  input  logic [bffa_pkg::PDATA_W-1:0]  pwdata,
  output logic [bffa_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic [bffa_pkg::REQ_W-1:0]    request_bytes,
  input  logic [bffa_pkg::FIRST_W-1:0]  free_block,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          status,
  output logic [bffa_pkg::START_W-1:0]  start_block
);
  import bffa_pkg::*;

  localparam int WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BLK_W = WA_W + BIT_W;
  localparam int CNT_W = BLK_W + 1;
  localparam int LEN_W = ((CNT_W > NEED_W) ? CNT_W : NEED_W) + 1;
  localparam logic [WORD_W-1:0] ALL_FREE = '1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_SCAN,
    ST_PREP,
    ST_MARK_RD,
    ST_MARK,
    ST_DONE
  } state_t;

  state_t state;

  logic [CFG_W-1:0]   blocks_in_use;
  logic               mode_r;
  logic [FIRST_W-1:0] first_r;
  logic [LEN_W-1:0]   need;
  logic [LEN_W-1:0]   carry;
  logic [WA_W-1:0]    cur_w;
  logic [BLK_W-1:0]   pool_last;
  logic [BLK_W-1:0]   range_lo;
  logic [BLK_W-1:0]   range_last;
  logic [LEN_W-1:0]   range_endx;
  logic               res_status;
  logic [START_W-1:0] res_start;

  logic [WORD_W-1:0]  mem [WORDS];
  logic [WORD_W-1:0]  rdata;
  logic [WA_W-1:0]    mem_raddr;
  logic               mem_we;
  logic [WA_W-1:0]    mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;

  logic               in_xfer;
  logic               div_done;
  logic [NEED_W-1:0]  div_quo;
  logic [NEED_W-1:0]  dividend;
  logic [LEN_W-1:0]   biu_ext;
  logic [LEN_W-1:0]   pool_n;
  logic [LEN_W-1:0]   free_sum;
  logic [WA_W-1:0]    pool_last_w;
  logic [WA_W-1:0]    lo_w;
  logic [WA_W-1:0]    last_w;
  logic [BIT_W-1:0]   pool_sh;
  logic [BIT_W-1:0]   hi_sh;
  logic [WORD_W-1:0]  scan_mask;
  logic [WORD_W-1:0]  lo_mask;
  logic [WORD_W-1:0]  hi_mask;
  logic [WORD_W-1:0]  mark_mask;
  scan_hit_t          scan_hit;
  logic [LEN_W-1:0]   run_out;
  logic [BLK_W-1:0]   scan_end;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BLOCKS_IN_USE) ? PDATA_W'(blocks_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use <= BIU_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_BLOCKS_IN_USE) begin
      blocks_in_use <= pwdata[CFG_W-1:0];
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  // Round the byte count up to whole blocks.
  assign dividend = NEED_W'(request_bytes) + NEED_W'(BLOCK_BYTES - 1);

  bffa_div #(
    .DIVISOR (BLOCK_BYTES)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (in_xfer),
    .dividend (dividend),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign biu_ext  = LEN_W'(blocks_in_use);
  assign pool_n   = (biu_ext > LEN_W'(MAX_BLOCKS)) ? LEN_W'(MAX_BLOCKS) : biu_ext;
  assign free_sum = LEN_W'(first_r) + need;

  assign pool_last_w = pool_last[BLK_W-1:BIT_W];
  assign lo_w        = range_lo[BLK_W-1:BIT_W];
  assign last_w      = range_last[BLK_W-1:BIT_W];
  assign pool_sh     = ~pool_last[BIT_W-1:0];
  assign hi_sh       = ~range_last[BIT_W-1:0];

  // Blocks beyond the pool read as busy so that no run crosses its end.
  assign scan_mask = (cur_w == pool_last_w) ? (ALL_FREE >> pool_sh) : ALL_FREE;
  assign lo_mask   = (cur_w == lo_w) ? (ALL_FREE << range_lo[BIT_W-1:0]) : ALL_FREE;
  assign hi_mask   = (cur_w == last_w) ? (ALL_FREE >> hi_sh) : ALL_FREE;
  assign mark_mask = lo_mask & hi_mask;

  bffa_word_scan #(
    .LEN_W (LEN_W)
  ) u_scan (
    .word    (rdata & scan_mask),
    .carry   (carry),
    .need    (need),
    .result  (scan_hit),
    .run_out (run_out)
  );

  assign scan_end = {cur_w, scan_hit.pos};

  // Memory port control. A read issued in one cycle returns data in the next;
  // the mark loop writes word k while it reads word k+1.
  always_comb begin
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = cur_w;
    mem_wdata = rdata;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = ALL_FREE;
      end
      ST_SCAN: begin
        mem_raddr = (cur_w == pool_last_w) ? cur_w : cur_w + 1'b1;
      end
      ST_MARK_RD: begin
        mem_raddr = lo_w;
      end
      ST_MARK: begin
        mem_we    = 1'b1;
        mem_wdata = (mode_r == MODE_FREE) ? (rdata | mark_mask) : (rdata & ~mark_mask);
        mem_raddr = (cur_w == last_w) ? cur_w : cur_w + 1'b1;
      end
      default: begin
        mem_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cur_w     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          cur_w <= cur_w + 1'b1;
          if (cur_w == WA_W'(WORDS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            mode_r  <= mode;
            first_r <= free_block;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            need  <= LEN_W'(div_quo);
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          res_start <= '0;
          pool_last <= BLK_W'(pool_n - 1'b1);
          if (mode_r == MODE_FREE) begin
            res_status <= STATUS_OK;
            if (need == '0 || LEN_W'(first_r) >= pool_n) begin
              state <= ST_DONE;
            end else begin
              range_lo   <= BLK_W'(first_r);
              range_endx <= (free_sum > pool_n) ? pool_n : free_sum;
              state      <= ST_PREP;
            end
          end else if (need == '0) begin
            res_status <= STATUS_OK;
            state      <= ST_DONE;
          end else if (need > pool_n) begin
            res_status <= STATUS_FULL;
            state      <= ST_DONE;
          end else begin
            res_status <= STATUS_OK;
            carry      <= '0;
            cur_w      <= '0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_hit.hit) begin
            range_last <= scan_end;
            state      <= ST_PREP;
          end else if (cur_w == pool_last_w) begin
            res_status <= STATUS_FULL;
            state      <= ST_DONE;
          end else begin
            carry <= run_out;
            cur_w <= cur_w + 1'b1;
          end
        end
        ST_PREP: begin
          if (mode_r == MODE_FREE) begin
            range_last <= BLK_W'(range_endx - 1'b1);
          end else begin
            range_lo <= BLK_W'(LEN_W'(range_last) - need + LEN_W'(1));
          end
          state <= ST_MARK_RD;
        end
        ST_MARK_RD: begin
          if (mode_r == MODE_ALLOC) begin
            res_start <= START_W'(range_lo);
          end
          cur_w <= lo_w;
          state <= ST_MARK;
        end
        ST_MARK: begin
          if (cur_w == last_w) begin
            state <= ST_DONE;
          end else begin
            cur_w <= cur_w + 1'b1;
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            start_block <= res_start;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_scan_in_pool: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> cur_w <= pool_last_w)
    else $error("scan walked past the last pool word");

  a_mark_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_MARK |-> (cur_w >= lo_w && cur_w <= last_w))
    else $error("mark loop outside the run's words");

  a_alloc_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MARK_RD && mode_r == MODE_ALLOC)
      |-> (LEN_W'(range_last) - LEN_W'(range_lo) + LEN_W'(1)) == need)
    else $error("allocated run length differs from the request");

  a_run_in_pool: assert property (@(posedge clk) disable iff (rst)
    state == ST_MARK_RD |-> (LEN_W'(range_last) < pool_n && range_lo <= range_last))
    else $error("run to mark lies outside the pool");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == ST_DIV)
    else $error("accepted transfer did not start the divider wait");

endmodule

>>> tb/sv/bitmap_first_fit_allocator_tb.sv
// ----------------------------------------------------------------------------
// Bitmap first-fit allocator testbench
// Drives allocate and free requests through the valid/stall channels with
// random gaps and back-pressure. A bit-level copy of the free map predicts
// every reply, and the pool size register is changed between phases.
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator_tb;
  import bffa_pkg::*;

  localparam int POOL_MAX   = 1024;
  localparam int CYCLE_CAP  = 1000000;
  localparam int HOLD_LEN   = 500;
  localparam logic [PADDR_W-1:0] ADDR_BLOCKS = PADDR_W'(4 * REG_BLOCKS_IN_USE);
  localparam logic [PADDR_W-1:0] ADDR_UNUSED = PADDR_W'(4);

  typedef struct {
    logic             st;
    logic [START_W-1:0] start;
  } alloc_reply_t;

  class alloc_tracker;
    bit [POOL_MAX-1:0] free_bits;
    bit [CFG_W-1:0]    blocks;
    alloc_reply_t      replies_due[$];
    int                live_at[$];
    int                live_len[$];
    int                n_taken;
    int                n_checked;
    int                n_refused;
    int                errors;

    function new();
      free_bits = '1;
      blocks    = BIU_RESET;
    endfunction

    // Updates the free map for one accepted transfer and queues its reply.
    function void take_request(logic m, logic [REQ_W-1:0] bytes,
                               logic [FIRST_W-1:0] first);
      int need;
      int pool;
      int run;
      int b;
      bit found;
      alloc_reply_t r;
      need    = (int'(bytes) + 15) / 16;
      pool    = (int'(blocks) > POOL_MAX) ? POOL_MAX : int'(blocks);
      r.st    = STATUS_OK;
      r.start = '0;
      found   = 0;
      run     = 0;
      n_taken++;
      if (m == MODE_FREE) begin
        for (int i = 0; i < need; i++) begin
          b = int'(first) + i;
          if (b >= pool) break;
          free_bits[b] = 1'b1;
        end
      end else if (need > 0) begin
        if (need <= pool) begin
          for (int i = 0; i < pool; i++) begin
            run = free_bits[i] ? run + 1 : 0;
            if (run == need) begin
              r.start = START_W'(i + 1 - need);
              found   = 1;
              break;
            end
          end
        end
        if (found) begin
          for (int i = 0; i < need; i++) free_bits[int'(r.start) + i] = 1'b0;
          live_at.push_back(int'(r.start));
          live_len.push_back(need);
        end else begin
          r.st    = STATUS_FULL;
          r.start = '0;
          n_refused++;
        end
      end
      replies_due.push_back(r);
    endfunction

    function void match_result(logic st, logic [START_W-1:0] start);
      alloc_reply_t r;
      if (replies_due.size() == 0) begin
        $error("reply transfer with no request outstanding: status %0d start_block %0d",
               st, start);
        errors++;
        return;
      end
      r = replies_due.pop_front();
      n_checked++;
      if (st !== r.st) begin
        $error("status: expected %0d, got %0d", r.st, st);
        errors++;
      end
      if (start !== r.start) begin
        $error("start_block: expected %0d, got %0d", r.start, start);
        errors++;
      end
    endfunction

    // Removes a random run from the list of live allocations.
    function bit take_live(output int at, output int len);
      int idx;
      if (live_at.size() == 0) return 0;
      idx = $urandom_range(0, live_at.size() - 1);
      at  = live_at[idx];
      len = live_len[idx];
      live_at.delete(idx);
      live_len.delete(idx);
      return 1;
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid;
  logic                in_stall;
  logic                mode;
  logic [REQ_W-1:0]    request_bytes;
  logic [FIRST_W-1:0]  free_block;
  logic                out_valid;
  logic                out_stall;
  logic                status;
  logic [START_W-1:0]  start_block;

  alloc_tracker tracker = new();
  int cycle_count = 0;
  int sizes_run   = 0;

  bitmap_first_fit_allocator dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .request_bytes(request_bytes), .free_block(free_block),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .start_block(start_block)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_CAP) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.match_result(status, start_block);
  end

  // Reply side: random stalls, a recurring quiet window, and one long
  // hold-off that lets the block fill up and stall its input.
  initial begin
    int stall_left;
    bit held;
    int roll;
    stall_left = 0;
    held       = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      roll = $urandom_range(0, 99);
      if (!held && tracker.n_checked >= 300) begin
        held      = 1;
        out_stall = 1'b1;
        repeat (HOLD_LEN) @(negedge clk);
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (cycle_count % 400 < 60 || roll < 70) begin
        out_stall = 1'b0;
      end else begin
        out_stall  = 1'b1;
        stall_left = (roll < 95) ? $urandom_range(0, 2) : $urandom_range(15, 60);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_request(logic m, logic [REQ_W-1:0] bytes,
                              logic [FIRST_W-1:0] first, int gap);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      = 1'b1;
    mode          = m;
    request_bytes = bytes;
    free_block    = first;
    do @(posedge clk); while (in_stall);
    tracker.take_request(m, bytes, first);
    @(negedge clk);
  endtask

  task automatic reg_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_BLOCKS) tracker.blocks = data[CFG_W-1:0];
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic reg_check(logic [PADDR_W-1:0] addr);
    logic [PDATA_W-1:0] want;
    want    = PDATA_W'(tracker.blocks);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = addr;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $error("prdata: expected %0d, got %0d", want, prdata);
      tracker.errors++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Waits at a falling edge until every queued reply has come back.
  task automatic drain();
    in_valid = 1'b0;
    while (tracker.replies_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic resize_pool(logic [PDATA_W-1:0] data);
    drain();
    reg_write(ADDR_BLOCKS, data);
    reg_check(ADDR_BLOCKS);
    sizes_run++;
  endtask

  function automatic int pick_gap(int k);
    int roll;
    roll = $urandom_range(0, 99);
    if (k % 128 < 24 || roll < 80) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // Mostly well-formed traffic: allocations of mixed sizes and frees of runs
  // that were handed out, with some arbitrary requests mixed in.
  task automatic run_traffic(int count);
    int roll;
    int need;
    int at;
    int len;
    logic [REQ_W-1:0] bytes;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (roll >= 45 && roll < 85 && tracker.take_live(at, len)) begin
        if ($urandom_range(0, 4) == 0) len = $urandom_range(0, len);
        bytes = (len == 0) ? '0 : REQ_W'(len * 16 - $urandom_range(0, 15));
        send_request(MODE_FREE, bytes, FIRST_W'(at), pick_gap(k));
      end else if (roll < 85) begin
        roll = $urandom_range(0, 99);
        if (roll < 60) need = $urandom_range(1, 8);
        else if (roll < 90) need = $urandom_range(9, 64);
        else need = $urandom_range(65, POOL_MAX);
        bytes = REQ_W'(need * 16 - $urandom_range(0, 15));
        send_request(MODE_ALLOC, bytes, FIRST_W'($urandom_range(0, 1023)), pick_gap(k));
      end else begin
        bytes = ($urandom_range(0, 1) != 0) ? REQ_W'($urandom_range(0, 16384))
                                            : REQ_W'($urandom_range(0, 160));
        send_request(logic'($urandom_range(0, 1)), bytes,
                     FIRST_W'($urandom_range(0, 1023)), pick_gap(k));
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    mode          = MODE_ALLOC;
    request_bytes = '0;
    free_block    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset size, then a write to an address past the register list.
    reg_check(ADDR_BLOCKS);
    reg_write(ADDR_UNUSED, 32'd7);
    reg_check(ADDR_BLOCKS);
    sizes_run = 1;

    send_request(MODE_ALLOC, 15'd0, 10'd0, 0);
    send_request(MODE_ALLOC, 15'd1, 10'h3FF, 0);
    send_request(MODE_ALLOC, 15'd16, 10'd0, 0);
    send_request(MODE_ALLOC, 15'd17, 10'd0, 1);
    send_request(MODE_ALLOC, 15'd16384, 10'd0, 0);
    send_request(MODE_FREE, 15'd16, 10'd0, 0);
    send_request(MODE_ALLOC, 15'd5, 10'd0, 0);
    send_request(MODE_FREE, 15'd16384, 10'd1023, 2);
    send_request(MODE_FREE, 15'd64, 10'd0, 0);
    send_request(MODE_FREE, 15'd64, 10'd0, 0);
    send_request(MODE_ALLOC, 15'd16384, 10'd0, 0);
    send_request(MODE_ALLOC, 15'd1, 10'd0, 0);
    send_request(MODE_ALLOC, 15'd0, 10'd0, 0);
    send_request(MODE_FREE, 15'd0, 10'h3FF, 0);
    send_request(MODE_FREE, 15'd16384, 10'd0, 0);
    send_request(MODE_ALLOC, 15'd16368, 10'd0, 0);
    send_request(MODE_ALLOC, 15'd32, 10'd0, 0);
    send_request(MODE_FREE, 15'd8176, 10'd512, 0);
    send_request(MODE_ALLOC, 15'd4096, 10'd0, 3);
    send_request(MODE_FREE, 15'd16384, 10'd0, 0);

    // Empty pool: nonzero allocations fail, zero-size still succeeds.
    resize_pool(32'd0);
    send_request(MODE_ALLOC, 15'd1, 10'd0, 0);
    send_request(MODE_ALLOC, 15'd0, 10'd0, 0);
    send_request(MODE_FREE, 15'd16, 10'd0, 0);

    // Largest register value saturates to the full pool.
    resize_pool(32'd2047);
    send_request(MODE_ALLOC, 15'd16384, 10'd0, 0);
    send_request(MODE_FREE, 15'd16384, 10'd0, 0);

    resize_pool(32'd1024);
    run_traffic(500);
    resize_pool(32'h0001_0021);
    run_traffic(120);
    resize_pool(32'd1);
    run_traffic(40);
    resize_pool(32'd0);
    run_traffic(30);
    resize_pool(32'd2047);
    run_traffic(300);
    resize_pool(32'd200);
    run_traffic(200);
    resize_pool(32'd700);
    run_traffic(200);
    resize_pool(32'd1024);
    run_traffic(160);

    drain();
    repeat (100) @(posedge clk);

    $display("Covered %0d request transfers and %0d checked replies over %0d pool sizes,",
             tracker.n_taken, tracker.n_checked, sizes_run);
    $display("including %0d refused allocations and a long reply hold-off.",
             tracker.n_refused);
    if (tracker.errors == 0 && tracker.replies_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d replies outstanding", tracker.errors,
               tracker.replies_due.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
